// ===== rtl/crtu_pkg.sv =====
`timescale 1ns / 1ps

package crtu_pkg;

    // field widths
    localparam int ADDR_W  = 32;
    localparam int DEPTH_W = 8;
    localparam int FUNC_W  = 10;
    localparam int CMD_W   = 2;
    localparam int KIND_W  = 2;

    // default sizes
    localparam int DEF_TABLE_ENTRIES    = 1024;
    localparam int DEF_TAIL_STACK_DEPTH = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CALL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RETURN = 2'd2;

    // report kinds
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CALL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RETURN = 2'd2;

    // depth limits
    localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 8'sh7f;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 8'sh80;

    // one function range
    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] size;
    } range_entry_t;

    // one unwound tail call record
    typedef struct packed {
        logic [ADDR_W-1:0]         pc;
        logic signed [DEPTH_W-1:0] depth;
    } tail_entry_t;

    // address falls in [start, start + size), end taken in 33 bits
    function automatic logic in_range(range_entry_t e, logic [ADDR_W-1:0] addr);
        logic [ADDR_W:0] lo;
        logic [ADDR_W:0] hi;
        logic [ADDR_W:0] a;
        lo = {1'b0, e.start_addr};
        hi = {1'b0, e.start_addr} + {1'b0, e.size};
        a  = {1'b0, addr};
        return (lo <= a) && (a < hi);
    endfunction

endpackage

// ===== rtl/call_return_trace_unit.sv =====
`timescale 1ns / 1ps

// Call and return tracer over a table of function ranges held in a synchronous
// memory with one write and one registered read port. A call or return report
// scans the stored ranges one entry per cycle, stopping once every address it
// looks up has been found; a call looks up pc and target in the same pass. A
// return that unwinds n tail records gives n + 1 reports, each costing one scan.
// Output stalls hold back the reports. Calls that leave the depth at one or less
// give no report.
// The table memory is only read at written entries, so it needs no clearing
// after reset. Results wait in an output register while the next request is
// taken, once the current one has delivered all its reports.

module call_return_trace_unit #(
    parameter int TABLE_ENTRIES    = crtu_pkg::DEF_TABLE_ENTRIES,
    parameter int TAIL_STACK_DEPTH = crtu_pkg::DEF_TAIL_STACK_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [crtu_pkg::CMD_W-1:0]          command,
    input  logic [crtu_pkg::ADDR_W-1:0]         pc,
    input  logic [crtu_pkg::ADDR_W-1:0]         target,
    input  logic                                is_tail,
    input  logic [crtu_pkg::ADDR_W-1:0]         sym_start,
    input  logic [crtu_pkg::ADDR_W-1:0]         sym_size,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [crtu_pkg::KIND_W-1:0]         kind,
    output logic signed [crtu_pkg::DEPTH_W-1:0] depth,
    output logic [crtu_pkg::ADDR_W-1:0]         report_pc,
    output logic                                pc_found,
    output logic [crtu_pkg::FUNC_W-1:0]         pc_func,
    output logic [crtu_pkg::ADDR_W-1:0]         report_target,
    output logic                                target_found,
    output logic [crtu_pkg::FUNC_W-1:0]         target_func,
    output logic                                table_full,
    output logic                                stack_overflow,
    output logic                                last
);
    import crtu_pkg::*;

    localparam int AW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW  = $clog2(TABLE_ENTRIES + 1);
    localparam int TW  = (TAIL_STACK_DEPTH > 1) ? $clog2(TAIL_STACK_DEPTH) : 1;
    localparam int TCW = $clog2(TAIL_STACK_DEPTH + 1);

    localparam logic [CW-1:0]  TABLE_LIMIT = CW'(TABLE_ENTRIES);
    localparam logic [TCW-1:0] STACK_LIMIT = TCW'(TAIL_STACK_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // control state
    logic [1:0]                state_reg, state_next;
    logic [CMD_W-1:0]          cmd_reg, cmd_next;
    logic signed [DEPTH_W-1:0] call_depth_reg, call_depth_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [TCW-1:0]            top_reg, top_next;
    logic                      full_reg, full_next;
    logic                      ovf_reg, ovf_next;
    logic [ADDR_W-1:0]         rpc_reg, rpc_next;
    logic [ADDR_W-1:0]         tgt_reg, tgt_next;

    // scan state
    logic [CW-1:0]             rd_idx_reg, rd_idx_next;
    logic [CW-1:0]             pend_idx_reg, pend_idx_next;
    logic                      pend_reg, pend_next;
    logic                      pcf_reg, pcf_next;
    logic [FUNC_W-1:0]         pci_reg, pci_next;
    logic                      tgf_reg, tgf_next;
    logic [FUNC_W-1:0]         tgi_reg, tgi_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]         kind_reg;
    logic signed [DEPTH_W-1:0] depth_reg;
    logic [ADDR_W-1:0]         report_pc_reg;
    logic                      pc_found_reg;
    logic [FUNC_W-1:0]         pc_func_reg;
    logic [ADDR_W-1:0]         report_target_reg;
    logic                      target_found_reg;
    logic [FUNC_W-1:0]         target_func_reg;
    logic                      table_full_reg;
    logic                      stack_overflow_reg;
    logic                      last_reg;

    // memory ports
    logic                      rm_wr_en;
    range_entry_t              rm_wr_data;
    logic                      rm_rd_en;
    range_entry_t              rm_rd_data;
    logic                      tm_wr_en;
    tail_entry_t               tm_wr_data;
    logic                      tm_rd_en;
    logic [TW-1:0]             tm_rd_addr;
    tail_entry_t               tm_rd_data;

    // helpers
    logic                      accept;
    logic                      out_load;
    logic                      need_tgt;
    logic                      scan_done;
    logic                      hit_pc;
    logic                      hit_tgt;
    logic                      unwind;
    logic signed [DEPTH_W-1:0] depth_inc;
    logic signed [DEPTH_W-1:0] depth_dec;
    logic [TCW-1:0]            top_m1;
    logic [TCW-1:0]            top_m2;

    // sub-blocks
    crtu_range_mem #(
        .ENTRIES (TABLE_ENTRIES),
        .AW      (AW)
    ) u_range_mem (
        .clk     (clk),
        .wr_en   (rm_wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (rm_wr_data),
        .rd_en   (rm_rd_en),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (rm_rd_data)
    );

    crtu_tail_mem #(
        .ENTRIES (TAIL_STACK_DEPTH),
        .AW      (TW)
    ) u_tail_mem (
        .clk     (clk),
        .wr_en   (tm_wr_en),
        .wr_addr (top_reg[TW-1:0]),
        .wr_data (tm_wr_data),
        .rd_en   (tm_rd_en),
        .rd_addr (tm_rd_addr),
        .rd_data (tm_rd_data)
    );

    // handshake and small arithmetic
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign need_tgt  = (cmd_reg == CMD_CALL);
    assign depth_inc = (call_depth_reg != DEPTH_MAX) ? call_depth_reg + 8'sd1 : call_depth_reg;
    assign depth_dec = (call_depth_reg != DEPTH_MIN) ? call_depth_reg - 8'sd1 : call_depth_reg;
    assign top_m1    = top_reg - TCW'(1);
    assign top_m2    = top_reg - TCW'(2);
    assign hit_pc    = pend_reg && in_range(rm_rd_data, rpc_reg);
    assign hit_tgt   = pend_reg && need_tgt && in_range(rm_rd_data, tgt_reg);
    assign scan_done = (pcf_reg && (tgf_reg || !need_tgt))
                       || (!pend_reg && (rd_idx_reg == count_reg));
    assign unwind    = (top_reg != '0) && (tm_rd_data.depth == depth_dec);

    assign rm_wr_data.start_addr = sym_start;
    assign rm_wr_data.size       = sym_size;
    assign tm_wr_data.pc         = pc;
    assign tm_wr_data.depth      = depth_inc - 8'sd1;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        call_depth_next = call_depth_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        full_next       = full_reg;
        ovf_next        = ovf_reg;
        rpc_next        = rpc_reg;
        tgt_next        = tgt_reg;
        rd_idx_next     = rd_idx_reg;
        pend_idx_next   = pend_idx_reg;
        pend_next       = pend_reg;
        pcf_next        = pcf_reg;
        pci_next        = pci_reg;
        tgf_next        = tgf_reg;
        tgi_next        = tgi_reg;
        rm_wr_en        = 1'b0;
        rm_rd_en        = 1'b0;
        tm_wr_en        = 1'b0;
        tm_rd_en        = 1'b0;
        tm_rd_addr      = top_m1[TW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                // fresh scan for whatever comes next
                rd_idx_next = '0;
                pend_next   = 1'b0;
                pcf_next    = 1'b0;
                pci_next    = '0;
                tgf_next    = 1'b0;
                tgi_next    = '0;
                if (accept)
                begin
                    cmd_next  = command;
                    rpc_next  = pc;
                    tgt_next  = target;
                    full_next = 1'b0;
                    ovf_next  = 1'b0;
                    case (command)
                        CMD_LOAD:
                        begin
                            if (sym_size != '0)
                            begin
                                if (count_reg < TABLE_LIMIT)
                                begin
                                    rm_wr_en   = 1'b1;
                                    count_next = count_reg + CW'(1);
                                end
                                else
                                begin
                                    full_next = 1'b1;
                                end
                            end
                            state_next = ST_EMIT;
                        end
                        CMD_CALL:
                        begin
                            call_depth_next = depth_inc;
                            if (depth_inc > 8'sd1)
                            begin
                                if (is_tail)
                                begin
                                    if (top_reg < STACK_LIMIT)
                                    begin
                                        tm_wr_en = 1'b1;
                                        top_next = top_reg + TCW'(1);
                                    end
                                    else
                                    begin
                                        ovf_next = 1'b1;
                                    end
                                end
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_RETURN:
                        begin
                            // peek the stack top while the scan runs
                            tm_rd_en   = (top_reg != '0);
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // compare the entry read last cycle
                if (hit_pc && !pcf_reg)
                begin
                    pcf_next = 1'b1;
                    pci_next = FUNC_W'(pend_idx_reg);
                end
                if (hit_tgt && !tgf_reg)
                begin
                    tgf_next = 1'b1;
                    tgi_next = FUNC_W'(pend_idx_reg);
                end
                if (scan_done)
                begin
                    pend_next  = 1'b0;
                    state_next = ST_EMIT;
                end
                else if (rd_idx_reg != count_reg)
                begin
                    rm_rd_en      = 1'b1;
                    rd_idx_next   = rd_idx_reg + CW'(1);
                    pend_idx_next = rd_idx_reg;
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            ST_EMIT:
            begin
                if (out_load)
                begin
                    if (cmd_reg == CMD_RETURN)
                    begin
                        call_depth_next = depth_dec;
                        if (unwind)
                        begin
                            // pop a tail record and report it too
                            top_next    = top_m1;
                            rpc_next    = tm_rd_data.pc;
                            tm_rd_en    = (top_reg > TCW'(1));
                            tm_rd_addr  = top_m2[TW-1:0];
                            rd_idx_next = '0;
                            pend_next   = 1'b0;
                            pcf_next    = 1'b0;
                            pci_next    = '0;
                            tgf_next    = 1'b0;
                            tgi_next    = '0;
                            state_next  = ST_SCAN;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            call_depth_reg <= '0;
            count_reg      <= '0;
            top_reg        <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            call_depth_reg <= call_depth_next;
            count_reg      <= count_next;
            top_reg        <= top_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        full_reg     <= full_next;
        ovf_reg      <= ovf_next;
        rpc_reg      <= rpc_next;
        tgt_reg      <= tgt_next;
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        pcf_reg      <= pcf_next;
        pci_reg      <= pci_next;
        tgf_reg      <= tgf_next;
        tgi_reg      <= tgi_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            case (cmd_reg)
                CMD_LOAD:
                begin
                    kind_reg           <= KIND_LOAD;
                    depth_reg          <= '0;
                    report_pc_reg      <= '0;
                    pc_found_reg       <= 1'b0;
                    pc_func_reg        <= '0;
                    report_target_reg  <= '0;
                    target_found_reg   <= 1'b0;
                    target_func_reg    <= '0;
                    table_full_reg     <= full_reg;
                    stack_overflow_reg <= 1'b0;
                    last_reg           <= 1'b1;
                end
                CMD_CALL:
                begin
                    kind_reg           <= KIND_CALL;
                    depth_reg          <= call_depth_reg;
                    report_pc_reg      <= rpc_reg;
                    pc_found_reg       <= pcf_reg;
                    pc_func_reg        <= pci_reg;
                    report_target_reg  <= tgt_reg;
                    target_found_reg   <= tgf_reg;
                    target_func_reg    <= tgi_reg;
                    table_full_reg     <= 1'b0;
                    stack_overflow_reg <= ovf_reg;
                    last_reg           <= 1'b1;
                end
                default:
                begin
                    kind_reg           <= KIND_RETURN;
                    depth_reg          <= call_depth_reg;
                    report_pc_reg      <= rpc_reg;
                    pc_found_reg       <= pcf_reg;
                    pc_func_reg        <= pci_reg;
                    report_target_reg  <= '0;
                    target_found_reg   <= 1'b0;
                    target_func_reg    <= '0;
                    table_full_reg     <= 1'b0;
                    stack_overflow_reg <= 1'b0;
                    last_reg           <= !unwind;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign depth          = depth_reg;
    assign report_pc      = report_pc_reg;
    assign pc_found       = pc_found_reg;
    assign pc_func        = pc_func_reg;
    assign report_target  = report_target_reg;
    assign target_found   = target_found_reg;
    assign target_func    = target_func_reg;
    assign table_full     = table_full_reg;
    assign stack_overflow = stack_overflow_reg;
    assign last           = last_reg;

endmodule

// ===== rtl/crtu_range_mem.sv =====
`timescale 1ns / 1ps

module crtu_range_mem #(
    parameter int ENTRIES = crtu_pkg::DEF_TABLE_ENTRIES,
    parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  crtu_pkg::range_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output crtu_pkg::range_entry_t rd_data
);
    import crtu_pkg::*;

    range_entry_t mem [ENTRIES];
    range_entry_t rd_data_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/crtu_tail_mem.sv =====
`timescale 1ns / 1ps

module crtu_tail_mem #(
    parameter int ENTRIES = crtu_pkg::DEF_TAIL_STACK_DEPTH,
    parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  crtu_pkg::tail_entry_t wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output crtu_pkg::tail_entry_t rd_data
);
    import crtu_pkg::*;

    tail_entry_t mem [ENTRIES];
    tail_entry_t rd_data_reg;

    // push port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered peek of the stack top
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/crtu_checker.sv =====
`timescale 1ns / 1ps

module crtu_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [crtu_pkg::KIND_W-1:0]         kind,
    input logic signed [crtu_pkg::DEPTH_W-1:0] depth,
    input logic [crtu_pkg::ADDR_W-1:0]         report_pc,
    input logic                                pc_found,
    input logic [crtu_pkg::FUNC_W-1:0]         pc_func,
    input logic [crtu_pkg::ADDR_W-1:0]         report_target,
    input logic                                target_found,
    input logic [crtu_pkg::FUNC_W-1:0]         target_func,
    input logic                                table_full,
    input logic                                stack_overflow,
    input logic                                last
);
    import crtu_pkg::*;

    // a load acknowledge is a single, empty report
    a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_LOAD) |->
            last && (depth == 0) && (report_pc == '0) && !pc_found
            && (report_target == '0) && !target_found && !stack_overflow)
        else $error("load acknowledge carries lookup or stack data");

    // return reports carry no target and no flags
    a_return_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_RETURN) |->
            (report_target == '0) && !target_found && (target_func == '0)
            && !table_full && !stack_overflow)
        else $error("return report carries target or flag data");

    // a miss reports index zero
    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (!pc_found || !target_found) |->
            (pc_found || (pc_func == '0)) && (target_found || (target_func == '0)))
        else $error("lookup miss with non-zero index");

    // calls report only from depth two upward
    a_call_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_CALL) |-> (depth > 8'sd1) && last && !table_full)
        else $error("call report at shallow depth or malformed");

    // a stalled report is held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(report_pc) && $stable(kind)
            && $stable(depth) && $stable(last))
        else $error("report changed while stalled");

endmodule

bind call_return_trace_unit crtu_checker u_crtu_checker (.*);
